/* src/kth_missing_positive_search_macros.svh */
// Assertion macros shared by the checker of the missing-positive search block.
`ifndef KTH_MISSING_POSITIVE_SEARCH_MACROS_SVH
`define KTH_MISSING_POSITIVE_SEARCH_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define KMPS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define KMPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/kmps_pkg.sv */
// Types and codes shared by the missing-positive search modules.
package kmps_pkg;

	localparam int OP_W      = 2;
	localparam int VALUE_W   = 31;
	localparam int RANK_W    = 31;
	localparam int RESULT_W  = 32;
	localparam int IN_DATA_W = 64;

	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [VALUE_W-1:0] element_value;
		logic [RANK_W-1:0]  want_rank;
	} in_t;

	typedef struct packed {
		logic [RESULT_W-1:0] missing_number;
		logic                overflow_seen;
	} res_t;

endpackage

/* src/kmps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module kmps_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* src/kmps_alu.sv */
// Shared adder and compare: forms k + index + carry and checks a stored element against it.
module kmps_alu
	import kmps_pkg::*;
#(
	parameter int ADDEND_W = 11
) (
	input  logic [RANK_W-1:0]   k,
	input  logic [ADDEND_W-1:0] addend,
	input  logic                cin,
	input  logic [VALUE_W-1:0]  mem_word,
	output logic [RESULT_W-1:0] sum,
	output logic                ge
);

	assign sum = RESULT_W'(k) + RESULT_W'(addend) + RESULT_W'(cin);
	// With carry in, ge means the missing count at the index is at least k.
	assign ge  = {1'b0, mem_word} >= sum;

endmodule

/* src/kmps_engine.sv */
// Sequencer: list bookkeeping and the probe-by-probe binary search of a query.
module kmps_engine
	import kmps_pkg::*;
#(
	parameter int MAX_ELEMS = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  in_t                          in_word,
	output logic                         res_valid,
	input  logic                         res_ready,
	output res_t                         res_word,
	output logic                         ram_we,
	output logic [$clog2(MAX_ELEMS)-1:0] ram_waddr,
	output logic [VALUE_W-1:0]           ram_wdata,
	output logic [$clog2(MAX_ELEMS)-1:0] ram_raddr,
	output logic [RANK_W-1:0]            alu_k,
	output logic [$clog2(MAX_ELEMS+1)-1:0] alu_addend,
	output logic                         alu_cin,
	input  logic [RESULT_W-1:0]          alu_sum,
	input  logic                         alu_ge
);

	localparam int AW = $clog2(MAX_ELEMS);
	localparam int CW = $clog2(MAX_ELEMS + 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_FIRST  = 3'd1;
	localparam logic [2:0] ST_LAST   = 3'd2;
	localparam logic [2:0] ST_SEARCH = 3'd3;
	localparam logic [2:0] ST_RESULT = 3'd4;

	logic [2:0]        state_q;
	logic [CW-1:0]     count_q;
	logic              ovf_q;
	logic              found_v_q;
	logic [RANK_W-1:0] k_q;
	logic [AW-1:0]     mid_q;
	logic [AW-1:0]     found_q;
	logic [CW-1:0]     low_q;
	logic [CW-1:0]     hi1_q;

	logic          accept;
	logic          full;
	logic [CW-1:0] last_cw;
	logic [AW-1:0] last_idx;
	logic [AW-1:0] mid0;
	logic [CW-1:0] mid_cw;
	logic [CW:0]   cand_ge_sum;
	logic [CW:0]   cand_lt_sum;
	logic [AW-1:0] cand_ge;
	logic [AW-1:0] cand_lt;
	logic          more_ge;
	logic          more_lt;
	logic [AW-1:0] mid_n;
	logic          more_n;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign full     = (count_q == CW'(MAX_ELEMS));

	assign ram_we    = accept && (in_word.op == OP_APPEND) && !full;
	assign ram_waddr = count_q[AW-1:0];
	assign ram_wdata = in_word.element_value;

	assign last_cw  = count_q - CW'(1);
	assign last_idx = last_cw[AW-1:0];
	assign mid0     = AW'(last_cw >> 1);
	assign mid_cw   = CW'(mid_q);

	// Both possible next midpoints come from registered bounds only, so the
	// compare result just selects one of them.
	assign cand_ge_sum = {1'b0, low_q} + {1'b0, mid_cw} - (CW+1)'(1);
	assign cand_lt_sum = {1'b0, mid_cw} + {1'b0, hi1_q};
	assign cand_ge     = cand_ge_sum[AW:1];
	assign cand_lt     = cand_lt_sum[AW:1];
	assign more_ge     = low_q < mid_cw;
	assign more_lt     = (mid_cw + CW'(1)) < hi1_q;
	assign mid_n       = alu_ge ? cand_ge : cand_lt;
	assign more_n      = alu_ge ? more_ge : more_lt;

	always_comb begin
		unique case (state_q)
			ST_FIRST:  ram_raddr = last_idx;
			ST_LAST:   ram_raddr = mid0;
			ST_SEARCH: ram_raddr = mid_n;
			default:   ram_raddr = '0;
		endcase
	end

	assign alu_k      = k_q;
	assign alu_cin    = (state_q != ST_RESULT);
	assign alu_addend = (state_q != ST_RESULT) ? mid_cw :
		(found_v_q ? CW'(found_q) : count_q);

	assign res_valid               = (state_q == ST_RESULT);
	assign res_word.missing_number = alu_sum;
	assign res_word.overflow_seen  = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			found_v_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (in_word.op)
							OP_CLEAR: begin
								count_q <= '0;
								ovf_q   <= 1'b0;
							end
							OP_APPEND: begin
								if (full) begin
									ovf_q <= 1'b1;
								end else begin
									count_q <= count_q + CW'(1);
								end
							end
							OP_QUERY: begin
								found_v_q <= 1'b0;
								state_q   <= (count_q == '0) ? ST_RESULT : ST_FIRST;
							end
							default: ;
						endcase
					end
				end
				ST_FIRST: begin
					if (alu_ge) begin
						found_v_q <= 1'b1;
						state_q   <= ST_RESULT;
					end else begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					state_q <= alu_ge ? ST_SEARCH : ST_RESULT;
				end
				ST_SEARCH: begin
					if (alu_ge) begin
						found_v_q <= 1'b1;
					end
					if (!more_n) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (in_word.op == OP_QUERY)) begin
					k_q   <= in_word.want_rank;
					mid_q <= '0;
				end
			end
			ST_FIRST: begin
				if (alu_ge) begin
					found_q <= '0;
				end else begin
					mid_q <= last_idx;
				end
			end
			ST_LAST: begin
				low_q <= '0;
				hi1_q <= count_q;
				mid_q <= mid0;
			end
			ST_SEARCH: begin
				if (alu_ge) begin
					found_q <= mid_q;
					hi1_q   <= mid_cw;
				end else begin
					low_q <= mid_cw + CW'(1);
				end
				mid_q <= mid_n;
			end
			default: ;
		endcase
	end

endmodule

/* src/kth_missing_positive_search.sv */
// Top level of the k-th missing positive search block.
//
//  channel | dir | carries
//  s_*     | in  | clear, append or query word (tuser = operation)
//  m_*     | out | answer word to a query (tuser = overflow flag)
//
// Clear and append words leave the sequencer idle; the block is ready again next cycle.
// A query checks the first element, then the last, then runs one binary-search probe at a
// time, each read through the one read port of the element RAM.
// The answer sits in an output register; a stalled answer holds the sequencer
// only when a second answer is ready to replace it.
// Reset clears the element count and overflow flag; the RAM needs no clearing.
module kth_missing_positive_search
	import kmps_pkg::*;
#(
	parameter int MAX_ELEMS = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,  // element_value [30:0], want_rank [61:31], zero
	input  logic [OP_W-1:0]      s_tuser,  // operation [1:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [RESULT_W-1:0]  m_tdata,  // missing_number [31:0]
	output logic                 m_tuser   // overflow_seen [0]
);

	localparam int AW = $clog2(MAX_ELEMS);
	localparam int CW = $clog2(MAX_ELEMS + 1);

	in_t  in_word;
	res_t res_word;
	logic res_valid;
	logic res_ready;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [VALUE_W-1:0] ram_wdata;
	logic [AW-1:0]      ram_raddr;
	logic [VALUE_W-1:0] ram_rdata;

	logic [RANK_W-1:0]   alu_k;
	logic [CW-1:0]       alu_addend;
	logic                alu_cin;
	logic [RESULT_W-1:0] alu_sum;
	logic                alu_ge;

	logic                m_tvalid_q;
	logic [RESULT_W-1:0] m_tdata_q;
	logic                m_tuser_q;

	assign in_word.op            = s_tuser;
	assign in_word.element_value = s_tdata[VALUE_W-1:0];
	assign in_word.want_rank     = s_tdata[VALUE_W+RANK_W-1:VALUE_W];

	kmps_engine #(
		.MAX_ELEMS(MAX_ELEMS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_word    (in_word),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_word   (res_word),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_raddr  (ram_raddr),
		.alu_k      (alu_k),
		.alu_addend (alu_addend),
		.alu_cin    (alu_cin),
		.alu_sum    (alu_sum),
		.alu_ge     (alu_ge)
	);

	kmps_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(MAX_ELEMS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	kmps_alu #(
		.ADDEND_W(CW)
	) u_alu (
		.k        (alu_k),
		.addend   (alu_addend),
		.cin      (alu_cin),
		.mem_word (ram_rdata),
		.sum      (alu_sum),
		.ge       (alu_ge)
	);

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_tdata_q <= res_word.missing_number;
			m_tuser_q <= res_word.overflow_seen;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

/* src/kmps_checker.sv */
// Port-level checks for the k-th missing positive search block, bound to the top level.
`include "kth_missing_positive_search_macros.svh"

module kmps_checker
	import kmps_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [OP_W-1:0]      s_tuser,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [RESULT_W-1:0]  m_tdata,
	input logic                 m_tuser
);

	logic in_acc;
	logic query_acc;

	assign in_acc    = s_tvalid && s_tready;
	assign query_acc = in_acc && (s_tuser == OP_QUERY);

	// A stalled answer word keeps its value.
	`KMPS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled answer word changed")

	// A query keeps the block busy for at least the following cycle.
	`KMPS_ASSERT_NEXT(a_query_busy, query_acc, !s_tready, "ready right after a query word")

	// Clear, append and unused words leave the block ready again in the next cycle.
	`KMPS_ASSERT_NEXT(a_list_op_quick, in_acc && !query_acc, s_tready,
		"not ready after a list word")

	// Only a query produces an answer word.
	`KMPS_ASSERT_NEXT(a_no_spurious, in_acc && !query_acc && !m_tvalid, !m_tvalid,
		"answer word without a query")

endmodule

bind kth_missing_positive_search kmps_checker u_kmps_checker (.*);

/* sim/kmps_answer_checker.sv */
// Checker that mirrors the missing-positive search block and compares its answer words.
module kmps_answer_checker
	import kmps_pkg::*;
#(
	parameter int MAX_ELEMS = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,  // element_value [30:0], want_rank [61:31], zero
	input  logic [OP_W-1:0]      s_tuser,  // operation [1:0]
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [RESULT_W-1:0]  m_tdata,  // missing_number [31:0]
	input  logic                 m_tuser,  // overflow_seen [0]
	output int                   error_count,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [VALUE_W-1:0] shadow_elems [MAX_ELEMS];
	int                 shadow_len;
	logic               shadow_overflow;
	res_t               answers_due [$];
	res_t               due;
	int                 fail_tally = 0;
	int                 due_count  = 0;

	assign error_count = fail_tally;
	assign pending     = due_count;

	// Missing positives below the element at idx, on signed 64-bit values so nothing wraps.
	function automatic longint missing_upto(input int idx);
		return longint'({33'd0, shadow_elems[idx]}) - longint'(idx) - 1;
	endfunction

	function automatic logic [RESULT_W-1:0] kth_absent(input logic [RANK_W-1:0] rank);
		longint want;
		longint lo;
		longint hi;
		longint mid;
		longint hit;
		logic [RESULT_W-1:0] rank_w;
		want   = longint'({33'd0, rank});
		rank_w = {1'b0, rank};
		if (shadow_len == 0)
			return rank_w;
		if (want <= longint'({33'd0, shadow_elems[0]}) - 1)
			return rank_w;
		if (want > missing_upto(shadow_len - 1))
			return rank_w + RESULT_W'(shadow_len);
		lo  = 0;
		hi  = shadow_len - 1;
		hit = -1;
		while (lo <= hi) begin
			mid = lo + (hi - lo) / 2;
			if (missing_upto(int'(mid)) >= want) begin
				hit = mid;
				hi  = mid - 1;
			end else begin
				lo = mid + 1;
			end
		end
		if (hit < 0)
			return rank_w + RESULT_W'(shadow_len);
		return RESULT_W'(hit) + rank_w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_len      = 0;
			shadow_overflow = 1'b0;
			answers_due.delete();
			due_count       = 0;
		end else begin
			// An answer word leaving now always belongs to an earlier query.
			if (m_tvalid && m_tready) begin
				if (answers_due.size() == 0) begin
					$error("answer word with no query waiting: missing_number %0d, overflow_seen %0d",
						m_tdata, m_tuser);
					fail_tally++;
				end else begin
					due = answers_due.pop_front();
					if (m_tdata !== due.missing_number) begin
						$error("missing_number: expected %0d, actual %0d",
							due.missing_number, m_tdata);
						fail_tally++;
					end
					if (m_tuser !== due.overflow_seen) begin
						$error("overflow_seen: expected %0d, actual %0d",
							due.overflow_seen, m_tuser);
						fail_tally++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					OP_CLEAR: begin
						shadow_len      = 0;
						shadow_overflow = 1'b0;
					end
					OP_APPEND: begin
						if (shadow_len < MAX_ELEMS) begin
							shadow_elems[shadow_len] = s_tdata[VALUE_W-1:0];
							shadow_len++;
						end else begin
							shadow_overflow = 1'b1;
						end
					end
					OP_QUERY: begin
						due.missing_number = kth_absent(s_tdata[VALUE_W+RANK_W-1:VALUE_W]);
						due.overflow_seen  = shadow_overflow;
						answers_due.insert(answers_due.size(), due);
					end
					default: ;
				endcase
			end
			due_count = answers_due.size();
		end
	end

endmodule

/* sim/tb_kth_missing_positive_search.sv */
// Testbench top for the missing-positive search block: stimulus, idling and verdict.
module tb_kth_missing_positive_search
	import kmps_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_ELEMS = 1024;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_WORDS = 500;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
	localparam logic [RANK_W-1:0] RANK_MAX = '1;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [IN_DATA_W-1:0] s_tdata;  // element_value [30:0], want_rank [61:31], zero
	logic [OP_W-1:0]      s_tuser;  // operation [1:0]
	logic                 m_tvalid;
	logic                 m_tready;
	logic [RESULT_W-1:0]  m_tdata;  // missing_number [31:0]
	logic                 m_tuser;  // overflow_seen [0]
	int                   error_count;
	int                   pending;

	bit     calm = 1'b0;
	int     idle_pct = 10;
	int     hold_asks = 0;
	int     words_sent = 0;
	longint list_first;
	longint list_last;
	int     list_len;

	kth_missing_positive_search #(
		.MAX_ELEMS(MAX_ELEMS)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	kmps_answer_checker #(
		.MAX_ELEMS(MAX_ELEMS)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.error_count(error_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#6_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Receiver side: random stall bursts, plus one long hold-off on request.
	initial begin
		int stall_left;
		int holds_done;
		stall_left = 0;
		holds_done = 0;
		m_tready   = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_done != hold_asks) begin
				holds_done = hold_asks;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && !calm && $urandom_range(0, 99) < idle_pct) begin
				stall_left = $urandom_range(1, 12);
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Offers one word and returns right after the edge that takes it.
	task automatic send_word(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
		input logic [RANK_W-1:0] rank);
		int gap;
		gap = (!calm && $urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 12) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {2'b00, rank, value};
		do @(posedge clk); while (!s_tready);
		if (op != OP_UNUSED)
			words_sent++;
	endtask

	task automatic clear_list();
		send_word(OP_CLEAR, VALUE_W'($urandom), RANK_W'($urandom));
		list_len = 0;
	endtask

	task automatic append_value(input logic [VALUE_W-1:0] value);
		send_word(OP_APPEND, value, RANK_W'($urandom));
		if (list_len == 0)
			list_first = value;
		list_last = value;
		list_len++;
	endtask

	task automatic ask(input logic [RANK_W-1:0] rank);
		send_word(OP_QUERY, VALUE_W'($urandom), rank);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// Picks k near the interesting points of the current ordered list.
	function automatic logic [RANK_W-1:0] pick_rank();
		longint top;
		longint k;
		if (list_len == 0)
			return RANK_W'($urandom);
		top = list_last - list_len;
		if (top < 0)
			top = 0;
		case ($urandom_range(0, 5))
			0: k = $urandom_range(0, int'(list_first));
			1, 2: k = $urandom_range(0, (top + 2 > RANK_MAX) ? RANK_MAX : int'(top + 2));
			3: k = top + $urandom_range(0, 1);
			4: k = $urandom;
			default: k = $urandom_range(0, 1);
		endcase
		return RANK_W'(k);
	endfunction

	task automatic ordered_run();
		int     target;
		int     queries;
		longint next_val;
		clear_list();
		target = ($urandom_range(0, 14) == 0) ? $urandom_range(13, 200) : $urandom_range(0, 12);
		case ($urandom_range(0, 7))
			0: next_val = 0;
			1, 2: next_val = $urandom_range(1, 32'h7FFF_FF00);
			default: next_val = $urandom_range(1, 50);
		endcase
		for (int i = 0; i < target; i++) begin
			if (next_val > VALUE_MAX)
				break;
			append_value(VALUE_W'(next_val));
			next_val += ($urandom_range(0, 7) == 0) ? $urandom_range(4, 1 << 20)
				: $urandom_range(1, 3);
		end
		queries = $urandom_range(1, 6);
		repeat (queries) ask(pick_rank());
	endtask

	task automatic noise_run();
		repeat ($urandom_range(1, 6)) begin
			case ($urandom_range(0, 3))
				0: send_word(OP_UNUSED, VALUE_W'($urandom), RANK_W'($urandom));
				1: send_word(OP_CLEAR, VALUE_W'($urandom), RANK_W'($urandom));
				default: send_word(OP_APPEND, VALUE_W'($urandom), RANK_W'($urandom));
			endcase
		end
		list_len = 0;
		repeat ($urandom_range(1, 4)) ask(RANK_W'($urandom));
	endtask

	initial begin
		int pick;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tuser  = OP_CLEAR;
		s_tdata  = '0;
		list_len = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty list, k at both ends, each branch of the search.
		ask(RANK_W'(0));
		ask(RANK_W'(1));
		ask(RANK_MAX);
		append_value(VALUE_W'(1));
		append_value(VALUE_W'(2));
		append_value(VALUE_W'(5));
		append_value(VALUE_W'(9));
		ask(RANK_W'(1));
		ask(RANK_W'(3));
		ask(RANK_W'(5));
		ask(RANK_W'(6));
		ask(RANK_W'(0));
		send_word(OP_UNUSED, VALUE_MAX, RANK_MAX);
		append_value(VALUE_MAX);
		ask(RANK_MAX);
		// A stored zero, then elements out of order.
		clear_list();
		append_value(VALUE_W'(0));
		ask(RANK_W'(0));
		ask(RANK_W'(1));
		clear_list();
		append_value(VALUE_W'(3));
		append_value(VALUE_W'(2));
		ask(RANK_W'(1));
		ask(RANK_W'(2));
		clear_list();
		append_value(VALUE_W'(10));
		ask(RANK_W'(9));
		ask(RANK_W'(10));

		// Fill the store, overflow it, then show that a clear drops the flag.
		clear_list();
		for (int i = 0; i < MAX_ELEMS; i++)
			append_value(VALUE_W'(2 * i + 1));
		append_value(VALUE_W'(5000));
		append_value(VALUE_W'(5001));
		ask(RANK_W'(1));
		ask(RANK_W'(1000));
		ask(RANK_W'(2000));
		ask(RANK_W'($urandom));
		clear_list();
		ask(RANK_W'(5));

		words_sent = 0;
		while (words_sent < RANDOM_WORDS) begin
			case ($urandom_range(0, 2))
				0: idle_pct = 0;
				1: idle_pct = 10;
				default: idle_pct = 35;
			endcase
			pick = $urandom_range(0, 9);
			if (pick < 8)
				ordered_run();
			else
				noise_run();
			if (hold_asks == 0 && words_sent > RANDOM_WORDS / 3) begin
				// Long receiver hold-off while queries keep coming, so the input backs up.
				hold_asks++;
				repeat (16) ask(pick_rank());
				wait_drained();
			end
			if (words_sent > RANDOM_WORDS * 4 / 5)
				calm = 1'b1;
		end

		wait_drained();
		repeat (40) @(posedge clk);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* kth_missing_positive_search.f */
+incdir+src
src/kmps_pkg.sv
src/kmps_ram.sv
src/kmps_alu.sv
src/kmps_engine.sv
src/kth_missing_positive_search.sv
src/kmps_checker.sv
sim/kmps_answer_checker.sv
sim/tb_kth_missing_positive_search.sv
